FILE: rtl/core/itp_pkg.sv
// Shared types, codes and the precedence function for the infix-to-postfix converter.
// This file has no dependencies. Every other file in rtl/core imports it.
package itp_pkg;

	// Token kinds on the input channel.
	localparam logic [1:0] CMD_OPERAND = 2'd0;
	localparam logic [1:0] CMD_OPER    = 2'd1;
	localparam logic [1:0] CMD_END     = 2'd2;

	// Operator codes that need special handling.
	localparam logic [3:0] OP_LPAREN = 4'd4;
	localparam logic [3:0] OP_RPAREN = 4'd5;

	// Result kinds.
	localparam logic [1:0] KIND_OPERAND  = 2'd0;
	localparam logic [1:0] KIND_OPERATOR = 2'd1;
	localparam logic [1:0] KIND_DONE     = 2'd2;

	// Status codes reported with the done item.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNMATCHED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// Depth of the token queue between front and back.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// Input item.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  op_code;
		logic [31:0] operand_value;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  out_op;
		logic [31:0] out_value;
		logic [7:0]  token_count;
		logic [1:0]  status;
		logic        last;
	} out_item_t;

	// Token class as decided by the front.
	typedef enum logic [2:0] {
		CL_OPERAND,
		CL_LPAREN,
		CL_RPAREN,
		CL_OPER,
		CL_END
	} tok_class_t;

	// Classified token held in the queue.
	typedef struct packed {
		tok_class_t  cls;
		logic [3:0]  op;
		logic [2:0]  prec;
		logic [31:0] value;
	} tok_t;

	// Queue fill status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Operator precedence; zero marks parentheses and unknown codes.
	function automatic logic [2:0] op_prec(input logic [3:0] op);
		logic [2:0] p;
		case (op)
			4'd0, 4'd1: p = 3'd1;
			4'd2, 4'd3: p = 3'd2;
			4'd6: p = 3'd3;
			4'd7, 4'd8, 4'd9, 4'd10, 4'd11: p = 3'd4;
			default: p = 3'd0;
		endcase
		return p;
	endfunction

endpackage

FILE: rtl/core/itp_front.sv
// Front end: accepts input items, classifies them and drops tokens that do nothing.
// Depends on itp_pkg.
module itp_front (
	input  logic             token_valid,
	output logic             token_stall,
	input  itp_pkg::in_item_t token,
	input  itp_pkg::q_stat_t  q_stat,
	output logic             q_push,
	output itp_pkg::tok_t     q_tok
);
	import itp_pkg::*;

	logic       keep;
	logic [2:0] prec;

	// Hold the source off only while the queue is full.
	assign token_stall = q_stat.full;

	// Classify the incoming token.
	always_comb begin
		prec          = op_prec(token.op_code);
		keep          = 1'b1;
		q_tok.cls     = CL_OPERAND;
		q_tok.op      = token.op_code;
		q_tok.prec    = prec;
		q_tok.value   = token.operand_value;
		case (token.cmd)
			CMD_OPERAND: q_tok.cls = CL_OPERAND;
			CMD_OPER: begin
				if (token.op_code == OP_LPAREN) begin
					q_tok.cls = CL_LPAREN;
				end else if (token.op_code == OP_RPAREN) begin
					q_tok.cls = CL_RPAREN;
				end else if (prec != 3'd0) begin
					q_tok.cls = CL_OPER;
				end else begin
					keep = 1'b0;
				end
			end
			CMD_END: q_tok.cls = CL_END;
			default: keep = 1'b0;
		endcase
	end

	// Only tokens with an effect go into the queue.
	assign q_push = token_valid && !token_stall && keep;

endmodule

FILE: rtl/core/itp_queue.sv
// Short token queue that decouples the front from the stack engine.
// Depends on itp_pkg.
module itp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  itp_pkg::tok_t     push_tok,
	input  logic             pop,
	output itp_pkg::tok_t     head,
	output itp_pkg::q_stat_t  stat
);
	import itp_pkg::*;

	tok_t             entry_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (cnt_q == Q_CW'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

FILE: rtl/core/itp_back.sv
// Back end: operator stack engine that turns classified tokens into postfix items.
// Depends on itp_pkg. The stack lives in a memory with the two top entries cached.
module itp_back #(
	parameter int STACK_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  itp_pkg::q_stat_t   q_stat,
	input  itp_pkg::tok_t      q_head,
	output logic              q_pop,
	output logic              result_valid,
	input  logic              result_stall,
	output itp_pkg::out_item_t result
);
	import itp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	state_t     state_q, state_d;
	tok_t       cur_q;
	logic [LW-1:0] level_q;
	logic [3:0] top_q;
	logic [3:0] nxt_q;
	logic [7:0] count_q;
	logic [1:0] err_q;
	logic       fin_q;
	logic       rvalid_q;
	out_item_t  res_q;
	logic [3:0] stack_mem_q [STACK_DEPTH];
	logic [3:0] rd_q;

	logic       out_free;
	logic       has_top, has_nxt, top_lp, nxt_lp;
	logic       top_beats, nxt_beats;
	logic       need_load, full;
	logic       emit, do_pop, do_push, push_ok, clr, fin, bump;
	logic [1:0] err_code;
	out_item_t  emit_item;
	logic [7:0] count_inc;
	logic [AW-1:0] rd_addr, wr_addr;

	// Stack view: the top two entries sit in registers.
	assign out_free  = !rvalid_q || !result_stall;
	assign has_top   = (level_q != '0);
	assign has_nxt   = (level_q >= LW'(2));
	assign top_lp    = (top_q == OP_LPAREN);
	assign nxt_lp    = (nxt_q == OP_LPAREN);
	assign top_beats = has_top && !top_lp && (op_prec(top_q) >= cur_q.prec);
	assign nxt_beats = has_nxt && !nxt_lp && (op_prec(nxt_q) >= cur_q.prec);
	assign need_load = (level_q >= LW'(3));
	assign full      = (level_q == LW'(STACK_DEPTH));
	assign rd_addr   = AW'(level_q - LW'(3));
	assign wr_addr   = AW'(level_q);
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 8'd1;

	// Decide what the current token does this cycle.
	always_comb begin
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_item = '0;
		do_pop    = 1'b0;
		do_push   = 1'b0;
		clr       = 1'b0;
		fin       = 1'b0;
		err_code  = ST_OK;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				if (!q_stat.empty) begin
					q_pop   = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (cur_q.cls)
					CL_OPERAND: begin
						if (out_free) begin
							emit                = 1'b1;
							emit_item.kind      = KIND_OPERAND;
							emit_item.out_value = cur_q.value;
							emit_item.last      = 1'b1;
							state_d             = S_IDLE;
						end
					end
					CL_LPAREN: begin
						do_push = 1'b1;
						state_d = S_IDLE;
					end
					CL_OPER: begin
						if (top_beats) begin
							if (out_free) begin
								emit             = 1'b1;
								emit_item.kind   = KIND_OPERATOR;
								emit_item.out_op = top_q;
								emit_item.last   = !nxt_beats;
								do_pop           = 1'b1;
							end
						end else begin
							do_push = 1'b1;
							state_d = S_IDLE;
						end
					end
					CL_RPAREN: begin
						if (!has_top) begin
							err_code = ST_UNMATCHED;
							state_d  = S_IDLE;
						end else if (top_lp) begin
							// Matching open paren: drop it silently and finish.
							do_pop = 1'b1;
							fin    = 1'b1;
						end else if (out_free) begin
							emit             = 1'b1;
							emit_item.kind   = KIND_OPERATOR;
							emit_item.out_op = top_q;
							emit_item.last   = !has_nxt || nxt_lp;
							do_pop           = 1'b1;
						end
					end
					CL_END: begin
						if (out_free) begin
							emit = 1'b1;
							if (has_top) begin
								emit_item.kind   = KIND_OPERATOR;
								emit_item.out_op = top_q;
								do_pop           = 1'b1;
							end else begin
								emit_item.kind        = KIND_DONE;
								emit_item.token_count = count_q;
								emit_item.status      = err_q;
								emit_item.last        = 1'b1;
								clr                   = 1'b1;
								state_d               = S_IDLE;
							end
						end
					end
					default: state_d = S_IDLE;
				endcase
				// A pop refills the second cached entry from memory when deep enough.
				if (do_pop) begin
					if (need_load) begin
						state_d = S_LOAD;
					end else if (fin) begin
						state_d = S_IDLE;
					end
				end
			end
			S_LOAD: state_d = fin_q ? S_IDLE : S_EXEC;
			default: state_d = S_IDLE;
		endcase
	end

	assign push_ok = do_push && !full;
	assign bump    = emit && (emit_item.kind != KIND_DONE);

	// Control state, stack cache and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			level_q  <= '0;
			count_q  <= '0;
			err_q    <= ST_OK;
			fin_q    <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cur_q <= q_head;
			end
			if (do_pop) begin
				fin_q <= fin;
			end
			// Stack level and cached top entries.
			if (clr) begin
				level_q <= '0;
			end else if (push_ok) begin
				level_q <= level_q + 1'b1;
				top_q   <= cur_q.op;
				nxt_q   <= top_q;
			end else if (do_pop) begin
				level_q <= level_q - 1'b1;
				top_q   <= nxt_q;
			end
			if (state_q == S_LOAD) begin
				nxt_q <= rd_q;
			end
			// Emitted count and sticky error.
			if (clr) begin
				count_q <= '0;
			end else if (bump) begin
				count_q <= count_inc;
			end
			if (clr) begin
				err_q <= ST_OK;
			end else if (err_q == ST_OK) begin
				if (do_push && full) begin
					err_q <= ST_OVERFLOW;
				end else if (err_code != ST_OK) begin
					err_q <= err_code;
				end
			end
			// Output register.
			if (emit) begin
				rvalid_q <= 1'b1;
				res_q    <= emit_item;
			end else if (!result_stall) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	// Stack memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			stack_mem_q[wr_addr] <= cur_q.op;
		end
		if (do_pop && need_load) begin
			rd_q <= stack_mem_q[rd_addr];
		end
	end

	assign result_valid = rvalid_q;
	assign result       = res_q;

endmodule

FILE: rtl/core/infix_to_postfix_converter.sv
// Channel   Payload              Handshake               Direction
// token     itp_pkg::in_item_t   token_valid/stall       into the block
// result    itp_pkg::out_item_t  result_valid/stall      out of the block
//
// The stack engine takes each token from the queue in S_IDLE and handles it in S_EXEC.
// An operator, an end token or a close paren pops stacked entries one at a time there;
// a close paren that finds its open paren pops that too and then returns to S_IDLE.
// A pop made while three or more entries are stacked passes through S_LOAD for the memory read.
// A 4-entry queue lets the front keep accepting while the engine works or results stall.
// arst_n clears the stack level, count, status and all handshake state; no clearing pass.
// Top level of the infix-to-postfix converter; depends on itp_pkg, itp_front,
// itp_queue and itp_back.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              token_valid,
	output logic              token_stall,
	input  itp_pkg::in_item_t  token,
	output logic              result_valid,
	input  logic              result_stall,
	output itp_pkg::out_item_t result
);
	import itp_pkg::*;

	q_stat_t q_stat;
	tok_t    q_tok;
	tok_t    q_head;
	logic    q_push;
	logic    q_pop;

	// Classify and accept tokens.
	itp_front u_front (
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token       (token),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_tok       (q_tok)
	);

	// Token queue.
	itp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_tok (q_tok),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	// Stack engine and result register.
	itp_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: rtl/core/itp_checker.sv
// Port-level checks for the infix-to-postfix converter, bound to the top level.
// Depends on itp_pkg and infix_to_postfix_converter.
module itp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              token_valid,
	input logic              token_stall,
	input itp_pkg::in_item_t  token,
	input logic              result_valid,
	input logic              result_stall,
	input itp_pkg::out_item_t result
);
	import itp_pkg::*;

	// A stalled input item holds until taken.
	a_token_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token))
		else $error("input item changed while stalled");

	// A stalled result holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The done item always closes its token's results.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_DONE) |-> result.last)
		else $error("done item without last");

	// Count and status appear only on the done item.
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind != KIND_DONE) |->
			(result.token_count == 8'd0) && (result.status == ST_OK))
		else $error("count or status on a non-done item");

	// An operand item is always the last result of its token.
	a_operand_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_OPERAND) |->
			result.last && (result.out_op == 4'd0))
		else $error("bad operand item");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

FILE: bench/tb_top.sv
// Self-checking testbench for the infix-to-postfix converter: directed and random token streams.
// It predicts the postfix items and done markers and checks every result in order.
// It depends on itp_pkg and the infix_to_postfix_converter top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import itp_pkg::*;

	localparam int STACK_DEPTH = 32;
	localparam int RANDOM_ITEMS = 310;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_AFTER = 60;
	localparam int HOLD_CYCLES = 200;

	// Operator codes as the token channel carries them.
	typedef enum logic [3:0] {
		OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_LPAREN, OPC_RPAREN, OPC_POW,
		OPC_SIN, OPC_COS, OPC_E, OPC_TAN, OPC_SQRT
	} op_code_e;

	localparam logic [3:0] OPC_UNKNOWN_LO = 4'd12;
	localparam logic [1:0] CMD_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic token_valid = 1'b0;
	logic token_stall;
	in_item_t token = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;

	in_item_t pending_tokens[$];
	out_item_t postfix_q[$];

	// Predicted state of the converter.
	logic [3:0] model_stack [STACK_DEPTH];
	int stack_top = 0;
	logic [7:0] emit_count = '0;
	logic [1:0] err_status = ST_OK;

	int tokens_accepted = 0;
	int tokens_total = -1;
	int results_seen = 0;
	int mismatches = 0;
	int stim_count = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token(token),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Precedence of a stacked or incoming operator; zero for parens and unknown codes.
	function automatic logic [2:0] rank(logic [3:0] op);
		case (op)
			OPC_ADD, OPC_SUB: return 3'd1;
			OPC_MUL, OPC_DIV: return 3'd2;
			OPC_POW: return 3'd3;
			OPC_SIN, OPC_COS, OPC_E, OPC_TAN, OPC_SQRT: return 3'd4;
			default: return 3'd0;
		endcase
	endfunction

	function automatic void bump_emitted();
		if (emit_count != COUNT_MAX)
			emit_count++;
	endfunction

	// The first error of an expression sticks until its end token.
	function automatic void raise_error(logic [1:0] code);
		if (err_status == ST_OK)
			err_status = code;
	endfunction

	function automatic void pop_op();
		out_item_t r;
		stack_top--;
		r = '0;
		r.kind = KIND_OPERATOR;
		r.out_op = model_stack[stack_top];
		postfix_q.push_back(r);
		bump_emitted();
	endfunction

	// A push onto a full stack drops the token and flags an overflow.
	function automatic void push_op(logic [3:0] op);
		if (stack_top >= STACK_DEPTH) begin
			raise_error(ST_OVERFLOW);
		end else begin
			model_stack[stack_top] = op;
			stack_top++;
		end
	endfunction

	// Works out the postfix items that one accepted token causes.
	function automatic void shunt_token(in_item_t t);
		int n0;
		bit matched;
		out_item_t r;
		n0 = postfix_q.size();
		r = '0;
		case (t.cmd)
			CMD_OPERAND: begin
				r.kind = KIND_OPERAND;
				r.out_value = t.operand_value;
				postfix_q.push_back(r);
				bump_emitted();
			end
			CMD_OPER: begin
				if (t.op_code == OPC_LPAREN) begin
					push_op(t.op_code);
				end else if (t.op_code == OPC_RPAREN) begin
					// Pop down to the matching open paren, or empty the stack.
					matched = 1'b0;
					while (stack_top > 0 && !matched) begin
						if (model_stack[stack_top - 1] == OPC_LPAREN) begin
							stack_top--;
							matched = 1'b1;
						end else begin
							pop_op();
						end
					end
					if (!matched)
						raise_error(ST_UNMATCHED);
				end else if (rank(t.op_code) != 0) begin
					while (stack_top > 0 && model_stack[stack_top - 1] != OPC_LPAREN &&
							rank(model_stack[stack_top - 1]) >= rank(t.op_code))
						pop_op();
					push_op(t.op_code);
				end
			end
			CMD_END: begin
				// Flush everything, leftover open parens too, then the done marker.
				while (stack_top > 0)
					pop_op();
				r.kind = KIND_DONE;
				r.token_count = emit_count;
				r.status = err_status;
				postfix_q.push_back(r);
				stack_top = 0;
				emit_count = '0;
				err_status = ST_OK;
			end
			default: ;
		endcase
		if (postfix_q.size() > n0) begin
			r = postfix_q.pop_back();
			r.last = 1'b1;
			postfix_q.push_back(r);
		end
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		results_seen++;
		if (postfix_q.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
		end else begin
			want = postfix_q.pop_front();
			compare_field("kind", 32'(want.kind), 32'(got.kind));
			compare_field("out_op", 32'(want.out_op), 32'(got.out_op));
			compare_field("out_value", want.out_value, got.out_value);
			compare_field("token_count", 32'(want.token_count), 32'(got.token_count));
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("last", 32'(want.last), 32'(got.last));
		end
	endfunction

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [3:0] pick_binary();
		case ($urandom_range(0, 4))
			0: return OPC_ADD;
			1: return OPC_SUB;
			2: return OPC_MUL;
			3: return OPC_DIV;
			default: return OPC_POW;
		endcase
	endfunction

	function automatic logic [3:0] pick_function();
		case ($urandom_range(0, 4))
			0: return OPC_SIN;
			1: return OPC_COS;
			2: return OPC_E;
			3: return OPC_TAN;
			default: return OPC_SQRT;
		endcase
	endfunction

	// Queues one item and counts it toward the item budget.
	function automatic void add_item(logic [1:0] cmd, logic [3:0] op, logic [31:0] v);
		in_item_t t;
		t.cmd = cmd;
		t.op_code = op;
		t.operand_value = v;
		pending_tokens.push_back(t);
		stim_count++;
	endfunction

	function automatic void add_operand();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			default: v = $urandom;
		endcase
		add_item(CMD_OPERAND, 4'($urandom), v);
	endfunction

	function automatic void add_oper(logic [3:0] op);
		add_item(CMD_OPER, op, $urandom);
	endfunction

	function automatic void add_end();
		add_item(CMD_END, 4'($urandom), $urandom);
	endfunction

	function automatic void add_noise();
		add_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom);
	endfunction

	// A well-formed expression with random operators, nesting and the odd broken token.
	function automatic void add_expression(int n_terms, int nest_odds);
		int open;
		open = 0;
		for (int i = 0; i < n_terms; i++) begin
			while ($urandom_range(0, nest_odds) == 0) begin
				if ($urandom_range(0, 1) == 0) begin
					add_oper(OPC_LPAREN);
					open++;
				end else begin
					add_oper(pick_function());
				end
			end
			if ($urandom_range(0, 29) == 0)
				add_noise();
			add_operand();
			while (open > 0 && $urandom_range(0, 2) == 0) begin
				add_oper(OPC_RPAREN);
				open--;
			end
			if (i != n_terms - 1)
				add_oper(pick_binary());
		end
		// Usually close what is open; otherwise the end token flushes the open parens.
		if ($urandom_range(0, 4) != 0) begin
			while (open > 0) begin
				add_oper(OPC_RPAREN);
				open--;
			end
		end
		if ($urandom_range(0, 9) == 0)
			add_oper(OPC_RPAREN);
		add_end();
	endfunction

	// Deep nesting that can overflow the stack; the closing parens may run past the opens.
	function automatic void add_deep_nest(int levels);
		for (int i = 0; i < levels; i++) begin
			if ($urandom_range(0, 3) == 0)
				add_oper(pick_function());
			else
				add_oper(OPC_LPAREN);
			if ($urandom_range(0, 3) == 0) begin
				add_operand();
				add_oper(pick_binary());
			end
		end
		add_operand();
		for (int i = 0; i < levels; i++)
			add_oper(OPC_RPAREN);
		add_end();
	endfunction

	// Token driver: presents queued items and predicts each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid <= 1'b0;
			token <= '0;
			gap_left <= 0;
		end else begin
			if (token_valid && !token_stall) begin
				shunt_token(token);
				tokens_accepted++;
			end
			if (!token_valid || !token_stall) begin
				if (gap_left != 0 && hold_left == 0) begin
					gap_left <= gap_left - 1;
					token_valid <= 1'b0;
				end else if (pending_tokens.size() != 0) begin
					token <= pending_tokens.pop_front();
					token_valid <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						tx_calm = !tx_calm;
					gap_left <= tx_calm ? 0 : pick_gap();
				end else begin
					token_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted item and drives a random stall pattern.
	always @(posedge clk or negedge arst_n) begin : result_side
		int g;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (result_valid && !result_stall)
				check_result(result);
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				// One long hold-off so the block fills up and stalls its input.
				hold_done = 1'b1;
				hold_left <= HOLD_CYCLES;
				result_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				result_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 39) == 0)
					rx_calm = !rx_calm;
				g = rx_calm ? 0 : pick_gap();
				stall_left <= (g > 0) ? g - 1 : 0;
				result_stall <= (g > 0);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int pick;

		// The binary operators, sine, extreme payloads and a parenthesised subexpression.
		add_item(CMD_OPERAND, 4'($urandom), 32'h0000_0000);
		add_oper(OPC_ADD);
		add_item(CMD_OPERAND, 4'($urandom), 32'hFFFF_FFFF);
		add_oper(OPC_MUL);
		add_oper(OPC_LPAREN);
		add_operand();
		add_oper(OPC_SUB);
		add_operand();
		add_oper(OPC_RPAREN);
		add_oper(OPC_POW);
		add_oper(OPC_SIN);
		add_operand();
		add_oper(OPC_DIV);
		add_operand();
		add_end();
		// An empty expression.
		add_end();
		// Close paren on an empty stack, the other functions, ignored items
		// and an open paren left for the end token to flush.
		add_oper(OPC_RPAREN);
		add_oper(OPC_COS);
		add_operand();
		add_oper(OPC_TAN);
		add_oper(OPC_SQRT);
		add_oper(OPC_E);
		add_operand();
		add_item(CMD_OPER, OPC_UNKNOWN_LO, $urandom);
		add_item(CMD_NOP, 4'($urandom), $urandom);
		add_oper(OPC_LPAREN);
		add_operand();
		add_end();

		// Random part, opened by one expression deep enough that it can overflow the stack.
		add_deep_nest(34 + $urandom_range(0, 6));
		while (stim_count < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				add_expression($urandom_range(1, 6), $urandom_range(2, 6));
			end else if (pick < 77) begin
				add_deep_nest($urandom_range(16, 38));
			end else if (pick < 89) begin
				repeat ($urandom_range(2, 8))
					add_noise();
				add_end();
			end else begin
				repeat ($urandom_range(2, 8)) begin
					if ($urandom_range(0, 1) == 0)
						add_operand();
					else
						add_oper(4'($urandom_range(0, int'(OPC_SQRT))));
				end
				add_end();
			end
		end
		tokens_total = pending_tokens.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (tokens_accepted != tokens_total)
			@(posedge clk);
		while (postfix_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/itp_pkg.sv
rtl/core/itp_front.sv
rtl/core/itp_queue.sv
rtl/core/itp_back.sv
rtl/core/infix_to_postfix_converter.sv
rtl/core/itp_checker.sv
bench/tb_top.sv
